FILE: design/fdc_pkg.sv
// Package for the flood-and-drain cycle controller.
// Holds state and fault codes, register indexes, reset values and item types.
// No dependencies.
package fdc_pkg;

    localparam int unsigned TIME_W      = 32;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CODE_W      = 3;
    localparam int unsigned DEFAULT_RETRY_LIMIT = 3;

    localparam logic [TIME_W:0] STUCK_MARGIN_MS = (TIME_W + 1)'(1000);

    localparam logic [TIME_W-1:0]  RST_FLOOD_INTERVAL = TIME_W'(3600000);
    localparam logic [TIME_W-1:0]  RST_FLOOD_DURATION = TIME_W'(60000);
    localparam logic [TIME_W-1:0]  RST_SOAK_DURATION  = TIME_W'(600000);
    localparam logic [TIME_W-1:0]  RST_DRAIN_TIMEOUT  = TIME_W'(1800000);
    localparam logic [COUNT_W-1:0] RST_RETRY_LIMIT    = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FLOOD_INTERVAL = 3'd0,
        REG_FLOOD_DURATION = 3'd1,
        REG_SOAK_DURATION  = 3'd2,
        REG_DRAIN_TIMEOUT  = 3'd3,
        REG_RETRY_LIMIT    = 3'd4
    } t_reg_idx;

    typedef enum logic [CODE_W-1:0] {
        ST_IDLE  = 3'd0,
        ST_FLOOD = 3'd1,
        ST_SOAK  = 3'd2,
        ST_DRAIN = 3'd3,
        ST_FAULT = 3'd4
    } t_cycle_state;

    typedef enum logic [CODE_W-1:0] {
        FC_NONE     = 3'd0,
        FC_DRY      = 3'd1,
        FC_OVERFLOW = 3'd2,
        FC_FLOOD_TO = 3'd3,
        FC_DRAIN_TO = 3'd4
    } t_fault_code;

    typedef struct packed {
        logic [TIME_W-1:0]  flood_interval;
        logic [TIME_W-1:0]  flood_duration;
        logic [TIME_W-1:0]  soak_duration;
        logic [TIME_W-1:0]  drain_timeout;
        logic [COUNT_W-1:0] retry_limit;
    } t_cfg;

    typedef struct packed {
        t_cycle_state       cycle_state;
        t_fault_code        fault_code;
        logic               latched;
        logic [TIME_W-1:0]  entry_time;
        logic [TIME_W-1:0]  cycle_start;
        logic [COUNT_W-1:0] overflow_events;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{
        cycle_state:     ST_IDLE,
        fault_code:      FC_NONE,
        latched:         1'b0,
        entry_time:      '0,
        cycle_start:     '0,
        overflow_events: '0
    };

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              fault_ack;
        logic              level_ok;
        logic              overflow_trip;
        logic              pump_on;
        logic              flood_now;
    } t_in_item;

    typedef struct packed {
        logic         pump_start;
        logic         pump_stop;
        logic         state_chg;
        logic         fault_chg;
        t_cycle_state cycle_state;
        t_fault_code  fault_code;
        logic         fault_is_latched;
    } t_out_item;

endpackage

FILE: design/fdc_ifs.sv
// Channel interfaces for the flood-and-drain cycle controller:
// sample request, result and configuration write channels.
// Depends on fdc_pkg.
interface fdc_req_if import fdc_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] now_ms;
    logic              fault_ack;
    logic              level_ok;
    logic              overflow_trip;
    logic              pump_on;
    logic              flood_now;

    modport source (output valid, now_ms, fault_ack, level_ok, overflow_trip,
                    pump_on, flood_now, input ready);
    modport sink   (input valid, now_ms, fault_ack, level_ok, overflow_trip,
                    pump_on, flood_now, output ready);
endinterface

interface fdc_rsp_if import fdc_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              pump_start;
    logic              pump_stop;
    logic              state_chg;
    logic              fault_chg;
    logic [CODE_W-1:0] cycle_state;
    logic [CODE_W-1:0] fault_code;
    logic              fault_is_latched;

    modport source (output valid, pump_start, pump_stop, state_chg, fault_chg,
                    cycle_state, fault_code, fault_is_latched, input ready);
    modport sink   (input valid, pump_start, pump_stop, state_chg, fault_chg,
                    cycle_state, fault_code, fault_is_latched, output ready);
endinterface

interface fdc_cfg_if import fdc_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/fdc_cfg_regs.sv
// Configuration register file of the flood-and-drain cycle controller.
// Depends on fdc_pkg and fdc_cfg_if.
module fdc_cfg_regs import fdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fdc_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FLOOD_INTERVAL: n_cfg.flood_interval = i_cfg.data[TIME_W-1:0];
                REG_FLOOD_DURATION: n_cfg.flood_duration = i_cfg.data[TIME_W-1:0];
                REG_SOAK_DURATION:  n_cfg.soak_duration  = i_cfg.data[TIME_W-1:0];
                REG_DRAIN_TIMEOUT:  n_cfg.drain_timeout  = i_cfg.data[TIME_W-1:0];
                REG_RETRY_LIMIT:    n_cfg.retry_limit    = i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flood_interval <= RST_FLOOD_INTERVAL;
            r_cfg.flood_duration <= RST_FLOOD_DURATION;
            r_cfg.soak_duration  <= RST_SOAK_DURATION;
            r_cfg.drain_timeout  <= RST_DRAIN_TIMEOUT;
            r_cfg.retry_limit    <= RST_RETRY_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/fdc_step.sv
// Single-step update of the pump cycle: next state and result flags for one sample.
// Purely combinational; depends on fdc_pkg.
module fdc_step import fdc_pkg::*; #(
    parameter int unsigned DEFAULT_RETRY_LIMIT = fdc_pkg::DEFAULT_RETRY_LIMIT
) (
    input  t_ctx      i_ctx,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_ctx      o_ctx,
    output t_out_item o_result
);

    t_ctx               n_ctx;
    logic               ovf_event;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  since_start;
    logic [COUNT_W-1:0] limit;
    logic               exhausted;
    logic               flood_expired;

    assign elapsed       = i_item.now_ms - i_ctx.entry_time;
    assign since_start   = i_item.now_ms - i_ctx.cycle_start;
    assign limit         = (i_cfg.retry_limit == '0) ? COUNT_W'(DEFAULT_RETRY_LIMIT)
                                                     : i_cfg.retry_limit;
    assign exhausted     = ({1'b0, i_ctx.overflow_events} + (COUNT_W + 1)'(1))
                           >= {1'b0, limit};
    assign flood_expired = {1'b0, elapsed} > ({1'b0, i_cfg.flood_duration} + STUCK_MARGIN_MS);

    // next state
    always_comb begin
        n_ctx     = i_ctx;
        ovf_event = 1'b0;
        if (i_item.fault_ack && i_ctx.latched) begin
            n_ctx.fault_code      = FC_NONE;
            n_ctx.latched         = 1'b0;
            n_ctx.overflow_events = '0;
            n_ctx.cycle_state     = i_item.level_ok ? ST_IDLE : ST_DRAIN;
            n_ctx.entry_time      = i_item.now_ms;
        end else if (i_ctx.cycle_state == ST_FAULT) begin
            n_ctx = i_ctx;
        end else if (i_item.overflow_trip &&
                     (i_ctx.cycle_state == ST_FLOOD || i_ctx.cycle_state == ST_SOAK)) begin
            ovf_event = 1'b1;
            if (i_ctx.overflow_events != '1) begin
                n_ctx.overflow_events = i_ctx.overflow_events + COUNT_W'(1);
            end
            n_ctx.fault_code  = FC_OVERFLOW;
            n_ctx.latched     = exhausted;
            n_ctx.cycle_state = exhausted ? ST_FAULT : ST_DRAIN;
            n_ctx.entry_time  = i_item.now_ms;
        end else begin
            unique case (i_ctx.cycle_state)
                ST_IDLE: begin
                    if (!i_item.level_ok) begin
                        n_ctx.fault_code = FC_DRY;
                        n_ctx.latched    = 1'b0;
                    end else begin
                        if (i_ctx.fault_code != FC_NONE && !i_ctx.latched) begin
                            n_ctx.fault_code = FC_NONE;
                        end
                        if (i_item.flood_now || since_start >= i_cfg.flood_interval) begin
                            n_ctx.cycle_state = ST_FLOOD;
                            n_ctx.entry_time  = i_item.now_ms;
                            n_ctx.cycle_start = i_item.now_ms;
                        end
                    end
                end
                ST_FLOOD: begin
                    if (flood_expired) begin
                        n_ctx.fault_code  = FC_FLOOD_TO;
                        n_ctx.latched     = 1'b1;
                        n_ctx.cycle_state = ST_FAULT;
                        n_ctx.entry_time  = i_item.now_ms;
                    end else if (!i_item.pump_on) begin
                        if (!i_item.overflow_trip && i_ctx.fault_code != FC_OVERFLOW) begin
                            n_ctx.overflow_events = '0;
                        end
                        if (i_ctx.fault_code != FC_NONE && !i_ctx.latched) begin
                            n_ctx.fault_code = FC_NONE;
                        end
                        n_ctx.cycle_state = ST_SOAK;
                        n_ctx.entry_time  = i_item.now_ms;
                    end
                end
                ST_SOAK: begin
                    if (elapsed >= i_cfg.soak_duration) begin
                        n_ctx.cycle_state = ST_DRAIN;
                        n_ctx.entry_time  = i_item.now_ms;
                    end
                end
                ST_DRAIN: begin
                    if (i_item.level_ok) begin
                        if (i_ctx.fault_code != FC_NONE && !i_ctx.latched) begin
                            n_ctx.fault_code = FC_NONE;
                        end
                        n_ctx.cycle_state = ST_IDLE;
                        n_ctx.entry_time  = i_item.now_ms;
                    end else if (elapsed >= i_cfg.drain_timeout) begin
                        n_ctx.fault_code = FC_DRAIN_TO;
                        n_ctx.latched    = 1'b0;
                    end
                end
                ST_FAULT: ;
                default: ;
            endcase
        end
    end

    // outputs
    always_comb begin
        o_result.pump_start       = (i_ctx.cycle_state == ST_IDLE) &&
                                    (n_ctx.cycle_state == ST_FLOOD);
        o_result.pump_stop        = ovf_event || (n_ctx.latched && !i_ctx.latched) ||
                                    ((i_ctx.cycle_state == ST_IDLE) &&
                                     !i_item.level_ok && i_item.pump_on);
        o_result.state_chg        = n_ctx.cycle_state != i_ctx.cycle_state;
        o_result.fault_chg        = ovf_event || (n_ctx.fault_code != i_ctx.fault_code) ||
                                    (n_ctx.latched != i_ctx.latched);
        o_result.cycle_state      = n_ctx.cycle_state;
        o_result.fault_code       = n_ctx.fault_code;
        o_result.fault_is_latched = n_ctx.latched;
    end

    assign o_ctx = n_ctx;

endmodule

FILE: design/flood_drain_cycle_controller_core.sv
// Top level of the flood-and-drain pump cycle controller.
// Depends on fdc_pkg, fdc_ifs, fdc_cfg_regs and fdc_step.
//
// Takes one sensor sample per request and returns one result per request.
// A request is accepted into an input register, evaluated by a single
// compare-and-update stage against the cycle state, and lands in a result
// register, from which the result is offered to the consumer; one
// request is taken every cycle while results are drained. The cycle state
// is updated as each request moves into the result register, so the next
// request sees it. Configuration writes are taken every cycle and are meant
// for when no request is in flight.
module flood_drain_cycle_controller_core import fdc_pkg::*; #(
    parameter int unsigned DEFAULT_RETRY_LIMIT = fdc_pkg::DEFAULT_RETRY_LIMIT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fdc_req_if.sink   i_req,
    fdc_rsp_if.source o_rsp,
    fdc_cfg_if.sink   i_cfg
);

    t_cfg      cfg;
    t_ctx      r_ctx;
    t_ctx      n_ctx;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      advance;
    logic      accept;

    fdc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fdc_step #(
        .DEFAULT_RETRY_LIMIT (DEFAULT_RETRY_LIMIT)
    ) u_step (
        .i_ctx    (r_ctx),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_ctx    (n_ctx),
        .o_result (n_out)
    );

    assign advance     = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || advance;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctx       <= CTX_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_ctx       <= n_ctx;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.now_ms        <= i_req.now_ms;
            r_in.fault_ack     <= i_req.fault_ack;
            r_in.level_ok      <= i_req.level_ok;
            r_in.overflow_trip <= i_req.overflow_trip;
            r_in.pump_on       <= i_req.pump_on;
            r_in.flood_now     <= i_req.flood_now;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.pump_start       = r_out.pump_start;
    assign o_rsp.pump_stop        = r_out.pump_stop;
    assign o_rsp.state_chg        = r_out.state_chg;
    assign o_rsp.fault_chg        = r_out.fault_chg;
    assign o_rsp.cycle_state      = r_out.cycle_state;
    assign o_rsp.fault_code       = r_out.fault_code;
    assign o_rsp.fault_is_latched = r_out.fault_is_latched;

endmodule

FILE: test/flood_drain_cycle_controller_core_tb.sv
// Self-checking testbench for flood_drain_cycle_controller_core: a directed sweep, then random
// sensor samples over several register settings, with results checked by predictor or table.
// Depends on fdc_pkg, fdc_ifs and the controller RTL.
module flood_drain_cycle_controller_core_tb import fdc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_ITEMS  = 120;
    localparam logic [TIME_W-1:0] MAX_DURATION = 32'hFFFF_FC17;

    typedef struct packed {
        t_in_item  sample;
        logic      typed;
        t_out_item result;
    } t_sweep_row;

    // flag order: ack, level ok, overflow, pump running, force
    localparam t_sweep_row SWEEP [24] = '{
        '{{32'd0,          5'b01000}, 1'b1, {4'b0000, ST_IDLE,  FC_NONE,     1'b0}},
        '{{32'd5,          5'b00010}, 1'b1, {4'b0101, ST_IDLE,  FC_DRY,      1'b0}},
        '{{32'd6,          5'b10000}, 1'b0, '0},
        '{{32'd7,          5'b01001}, 1'b0, '0},
        '{{32'd8,          5'b01110}, 1'b0, '0},
        '{{32'd9,          5'b01000}, 1'b0, '0},
        '{{32'hFFFF_FFFF,  5'b01000}, 1'b1, {4'b1010, ST_FLOOD, FC_NONE,     1'b0}},
        '{{32'd10,         5'b01110}, 1'b0, '0},
        '{{32'd11,         5'b01000}, 1'b0, '0},
        '{{32'd12,         5'b01001}, 1'b0, '0},
        '{{32'd13,         5'b01110}, 1'b1, {4'b0111, ST_FAULT, FC_OVERFLOW, 1'b1}},
        '{{32'd14,         5'b01111}, 1'b0, '0},
        '{{32'd15,         5'b10000}, 1'b1, {4'b0011, ST_DRAIN, FC_NONE,     1'b0}},
        '{{32'd1800015,    5'b00000}, 1'b1, {4'b0001, ST_DRAIN, FC_DRAIN_TO, 1'b0}},
        '{{32'd1800016,    5'b01000}, 1'b0, '0},
        '{{32'd1800017,    5'b01001}, 1'b0, '0},
        '{{32'd1861017,    5'b01010}, 1'b0, '0},
        '{{32'd1861018,    5'b01010}, 1'b1, {4'b0111, ST_FAULT, FC_FLOOD_TO, 1'b1}},
        '{{32'd1861019,    5'b11000}, 1'b0, '0},
        '{{32'd1861020,    5'b01001}, 1'b0, '0},
        '{{32'd1861021,    5'b01000}, 1'b0, '0},
        '{{32'd2461020,    5'b01000}, 1'b0, '0},
        '{{32'd2461021,    5'b01000}, 1'b0, '0},
        '{{32'd2461022,    5'b01000}, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    fdc_req_if req_ch ();
    fdc_rsp_if rsp_ch ();
    fdc_cfg_if cfg_ch ();

    flood_drain_cycle_controller_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    t_cfg              sched_cfg;
    t_ctx              cycle_ctx;
    t_out_item         pending_results[$];
    logic [TIME_W-1:0] wall_ms;
    int unsigned       burst_left;
    int unsigned       cycle_count;
    int unsigned       mismatch_count;
    bit                hold_rsp_long;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void enter_state(inout t_out_item r, input t_cycle_state st,
                                        input logic [TIME_W-1:0] at);
        cycle_ctx.cycle_state = st;
        cycle_ctx.entry_time  = at;
        r.state_chg           = 1'b1;
    endfunction

    function automatic void latch_fault(inout t_out_item r, input t_fault_code code,
                                        input logic [TIME_W-1:0] at);
        cycle_ctx.fault_code = code;
        cycle_ctx.latched    = 1'b1;
        enter_state(r, ST_FAULT, at);
        r.pump_stop = 1'b1;
        r.fault_chg = 1'b1;
    endfunction

    function automatic void raise_advisory(inout t_out_item r, input t_fault_code code);
        if (cycle_ctx.fault_code != code || cycle_ctx.latched) begin
            r.fault_chg = 1'b1;
        end
        cycle_ctx.fault_code = code;
        cycle_ctx.latched    = 1'b0;
    endfunction

    function automatic void retire_advisory(inout t_out_item r);
        if (cycle_ctx.fault_code != FC_NONE && !cycle_ctx.latched) begin
            cycle_ctx.fault_code = FC_NONE;
            r.fault_chg          = 1'b1;
        end
    endfunction

    function automatic t_out_item advance_cycle(input t_in_item s);
        t_out_item          r;
        logic [TIME_W-1:0]  in_state;
        logic [TIME_W-1:0]  since_start;
        logic [COUNT_W:0]   retry_cap;
        logic               used_up;
        r           = '0;
        in_state    = s.now_ms - cycle_ctx.entry_time;
        since_start = s.now_ms - cycle_ctx.cycle_start;
        retry_cap   = (sched_cfg.retry_limit == '0) ? (COUNT_W + 1)'(DEFAULT_RETRY_LIMIT)
                                                    : {1'b0, sched_cfg.retry_limit};
        if (s.fault_ack && cycle_ctx.latched) begin
            cycle_ctx.fault_code      = FC_NONE;
            cycle_ctx.latched         = 1'b0;
            cycle_ctx.overflow_events = '0;
            enter_state(r, s.level_ok ? ST_IDLE : ST_DRAIN, s.now_ms);
            r.fault_chg = 1'b1;
        end else if (cycle_ctx.cycle_state == ST_FAULT) begin
            // hold until acknowledged
        end else if (s.overflow_trip &&
                     (cycle_ctx.cycle_state == ST_FLOOD || cycle_ctx.cycle_state == ST_SOAK)) begin
            used_up     = ({1'b0, cycle_ctx.overflow_events} + 1'b1) >= retry_cap;
            r.pump_stop = 1'b1;
            if (cycle_ctx.overflow_events != '1) begin
                cycle_ctx.overflow_events += 1'b1;
            end
            if (used_up) begin
                latch_fault(r, FC_OVERFLOW, s.now_ms);
            end else begin
                enter_state(r, ST_DRAIN, s.now_ms);
                cycle_ctx.fault_code = FC_OVERFLOW;
                cycle_ctx.latched    = 1'b0;
                r.fault_chg          = 1'b1;
            end
        end else begin
            case (cycle_ctx.cycle_state)
                ST_IDLE: begin
                    if (!s.level_ok) begin
                        if (s.pump_on) begin
                            r.pump_stop = 1'b1;
                        end
                        raise_advisory(r, FC_DRY);
                    end else begin
                        retire_advisory(r);
                        if (s.flood_now || since_start >= sched_cfg.flood_interval) begin
                            enter_state(r, ST_FLOOD, s.now_ms);
                            cycle_ctx.cycle_start = s.now_ms;
                            r.pump_start          = 1'b1;
                        end
                    end
                end
                ST_FLOOD: begin
                    if ({1'b0, in_state} > {1'b0, sched_cfg.flood_duration} + STUCK_MARGIN_MS) begin
                        latch_fault(r, FC_FLOOD_TO, s.now_ms);
                    end else if (!s.pump_on) begin
                        if (!s.overflow_trip && cycle_ctx.fault_code != FC_OVERFLOW) begin
                            cycle_ctx.overflow_events = '0;
                        end
                        retire_advisory(r);
                        enter_state(r, ST_SOAK, s.now_ms);
                    end
                end
                ST_SOAK: begin
                    if (in_state >= sched_cfg.soak_duration) begin
                        enter_state(r, ST_DRAIN, s.now_ms);
                    end
                end
                ST_DRAIN: begin
                    if (s.level_ok) begin
                        retire_advisory(r);
                        enter_state(r, ST_IDLE, s.now_ms);
                    end else if (in_state >= sched_cfg.drain_timeout) begin
                        raise_advisory(r, FC_DRAIN_TO);
                    end
                end
                default: begin
                end
            endcase
        end
        r.cycle_state      = cycle_ctx.cycle_state;
        r.fault_code       = cycle_ctx.fault_code;
        r.fault_is_latched = cycle_ctx.latched;
        return r;
    endfunction

    // Move the wall clock on, or now and then to a random time, and mostly shape the flags so the cycle keeps moving.
    function automatic t_in_item next_sample();
        t_in_item    s;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
            wall_ms += $urandom_range(0, 15);
        end else if (roll < 95) begin
            wall_ms += $urandom_range(0, 400);
        end else begin
            wall_ms = $urandom();
        end
        s        = '0;
        s.now_ms = wall_ms;
        if ($urandom_range(0, 9) == 0) begin
            {s.fault_ack, s.level_ok, s.overflow_trip, s.pump_on,
             s.flood_now} = 5'($urandom());
            return s;
        end
        s.fault_ack     = ($urandom_range(0, 15) == 0);
        s.level_ok      = ($urandom_range(0, 7) != 0);
        s.overflow_trip = ($urandom_range(0, 11) == 0);
        s.pump_on       = 1'($urandom_range(0, 1));
        s.flood_now     = ($urandom_range(0, 9) == 0);
        case (cycle_ctx.cycle_state)
            ST_FLOOD: begin
                s.pump_on       = ($urandom_range(0, 9) != 0);
                s.overflow_trip = ($urandom_range(0, 7) == 0);
            end
            ST_DRAIN: s.level_ok = ($urandom_range(0, 3) == 0);
            ST_FAULT: s.fault_ack = ($urandom_range(0, 3) == 0);
            default: begin
            end
        endcase
        return s;
    endfunction

    task automatic offer_sample(input t_in_item s, input logic typed, input t_out_item typed_res);
        t_out_item predicted;
        int unsigned gap;
        req_ch.valid         <= 1'b1;
        req_ch.now_ms        <= s.now_ms;
        req_ch.fault_ack     <= s.fault_ack;
        req_ch.level_ok      <= s.level_ok;
        req_ch.overflow_trip <= s.overflow_trip;
        req_ch.pump_on       <= s.pump_on;
        req_ch.flood_now     <= s.flood_now;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = advance_cycle(s);
        pending_results.push_back(typed ? typed_res : predicted);
        if (burst_left == 0) begin
            burst_left   = $urandom_range(1, 40);
            gap          = $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_FLOOD_INTERVAL: sched_cfg.flood_interval = d;
            REG_FLOOD_DURATION: sched_cfg.flood_duration = d;
            REG_SOAK_DURATION:  sched_cfg.soak_duration  = d;
            REG_DRAIN_TIMEOUT:  sched_cfg.drain_timeout  = d;
            REG_RETRY_LIMIT:    sched_cfg.retry_limit    = d[COUNT_W-1:0];
            default: begin
            end
        endcase
    endtask

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("pump_start", want.pump_start, rsp_ch.pump_start);
                check_field("pump_stop", want.pump_stop, rsp_ch.pump_stop);
                check_field("state_chg", want.state_chg, rsp_ch.state_chg);
                check_field("fault_chg", want.fault_chg, rsp_ch.fault_chg);
                check_field("cycle_state", want.cycle_state, rsp_ch.cycle_state);
                check_field("fault_code", want.fault_code, rsp_ch.fault_code);
                check_field("fault_is_latched", want.fault_is_latched, rsp_ch.fault_is_latched);
            end
        end
    end

    initial begin
        int unsigned style;
        int unsigned span;
        rsp_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_rsp_long) begin
                hold_rsp_long = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 150);
            repeat (span) begin
                case (style)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("flood_drain_cycle_controller_core: mismatch");
        $finish;
    end

    initial begin
        t_cfg setting;
        i_rst_n              <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.now_ms        <= '0;
        req_ch.fault_ack     <= 1'b0;
        req_ch.level_ok      <= 1'b0;
        req_ch.overflow_trip <= 1'b0;
        req_ch.pump_on       <= 1'b0;
        req_ch.flood_now     <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_FLOOD_INTERVAL;
        cfg_ch.data          <= '0;
        mismatch_count = 0;
        hold_rsp_long  = 1'b0;
        burst_left     = 0;
        wall_ms        = '0;
        cycle_ctx      = CTX_RESET;
        sched_cfg      = '{RST_FLOOD_INTERVAL, RST_FLOOD_DURATION, RST_SOAK_DURATION,
                           RST_DRAIN_TIMEOUT, RST_RETRY_LIMIT};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (SWEEP[i]) begin
            offer_sample(SWEEP[i].sample, SWEEP[i].typed, SWEEP[i].result);
        end
        wall_ms = SWEEP[23].sample.now_ms;

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            req_ch.valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            case (ph)
                1: setting = '{32'd0, 32'd0, 32'd0, 32'd0, 8'd0};
                2: setting = '{32'hFFFF_FFFF, MAX_DURATION, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255};
                3: setting = '{$urandom(), $urandom_range(0, MAX_DURATION), $urandom(), $urandom(),
                               8'($urandom_range(0, 255))};
                default: setting = '{$urandom_range(20, 200), $urandom_range(10, 80),
                                     $urandom_range(5, 60), $urandom_range(10, 100),
                                     (ph == 0) ? 8'd1 : 8'($urandom_range(0, 6))};
            endcase
            write_reg(REG_FLOOD_INTERVAL, setting.flood_interval);
            write_reg(REG_FLOOD_DURATION, setting.flood_duration);
            write_reg(REG_SOAK_DURATION, setting.soak_duration);
            write_reg(REG_DRAIN_TIMEOUT, setting.drain_timeout);
            write_reg(REG_RETRY_LIMIT, CFG_DATA_W'(setting.retry_limit));
            cfg_ch.valid <= 1'b0;
            if (ph == 4) begin
                hold_rsp_long = 1'b1;
            end
            repeat (PHASE_ITEMS) offer_sample(next_sample(), 1'b0, '0);
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("flood_drain_cycle_controller_core: match");
        end else begin
            $display("flood_drain_cycle_controller_core: mismatch");
        end
        $finish;
    end

endmodule
